[hw/rtl/segrast_pkg.sv]
package segrast_pkg;

  localparam int COORD_W = 6;
  localparam int REG_W   = 7;
  localparam int ERR_W   = COORD_W + 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] MAP_WIDTH_RESET  = REG_W'(64);
  localparam logic [REG_W-1:0] MAP_HEIGHT_RESET = REG_W'(64);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_step;
  } dp_status_t;

endpackage

[hw/rtl/segrast_cfg.sv]
module segrast_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [segrast_pkg::ADDR_W-1:0]       paddr,
  input  logic [segrast_pkg::DATA_W-1:0]       pwdata,
  output logic [segrast_pkg::DATA_W-1:0]       prdata,
  output logic                                 pready,
  output logic [segrast_pkg::REG_W-1:0]        map_width,
  output logic [segrast_pkg::REG_W-1:0]        map_height
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= segrast_pkg::MAP_WIDTH_RESET;
      map_height <= segrast_pkg::MAP_HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        segrast_pkg::REG_MAP_WIDTH:  map_width  <= pwdata[segrast_pkg::REG_W-1:0];
        segrast_pkg::REG_MAP_HEIGHT: map_height <= pwdata[segrast_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      segrast_pkg::REG_MAP_WIDTH:
        prdata = {{(segrast_pkg::DATA_W - segrast_pkg::REG_W){1'b0}}, map_width};
      segrast_pkg::REG_MAP_HEIGHT:
        prdata = {{(segrast_pkg::DATA_W - segrast_pkg::REG_W){1'b0}}, map_height};
      default:
        prdata = '0;
    endcase
  end

endmodule

[hw/rtl/segrast_ctrl.sv]
module segrast_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  segrast_pkg::dp_status_t status,
  output segrast_pkg::dp_cmd_t    cmd
);

  segrast_pkg::ctrl_state_t state;
  segrast_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= segrast_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      segrast_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = segrast_pkg::ST_SETUP;
        end
      end
      segrast_pkg::ST_SETUP: begin
        state_next = segrast_pkg::ST_RUN;
      end
      segrast_pkg::ST_RUN: begin
        if (status.slot_free && status.last_step) begin
          state_next = segrast_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = segrast_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.setup = 1'b0;
    cmd.step  = 1'b0;
    unique case (state)
      segrast_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      segrast_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      segrast_pkg::ST_RUN: begin
        cmd.step = status.slot_free;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/segrast_datapath.sv]
module segrast_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  segrast_pkg::dp_cmd_t                 cmd,
  output segrast_pkg::dp_status_t              status,
  input  logic [segrast_pkg::COORD_W-1:0]      start_x,
  input  logic [segrast_pkg::COORD_W-1:0]      start_y,
  input  logic [segrast_pkg::COORD_W-1:0]      end_x,
  input  logic [segrast_pkg::COORD_W-1:0]      end_y,
  input  logic [segrast_pkg::REG_W-1:0]        map_width,
  input  logic [segrast_pkg::REG_W-1:0]        map_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [segrast_pkg::COORD_W-1:0]      tile_x,
  output logic [segrast_pkg::COORD_W-1:0]      tile_y,
  output logic                                 in_map,
  output logic                                 last
);

  localparam int CW = segrast_pkg::COORD_W;
  localparam int EW = segrast_pkg::ERR_W;

  logic [CW-1:0] x1, y1, x2, y2;

  logic [CW-1:0] major;
  logic [CW-1:0] minor;
  logic [CW-1:0] cnt;
  logic [CW:0]   two_n;
  logic signed [CW+1:0] d2;
  logic signed [EW-1:0] err;
  logic          x_major;

  logic [CW-1:0] adx, ady;
  logic          setup_x_major;
  logic [CW-1:0] setup_lo, setup_a, setup_b, setup_span;
  logic signed [CW:0] setup_d;

  logic signed [EW-1:0] err_sum;
  logic signed [EW-1:0] two_n_s;
  logic [CW-1:0] step_tx, step_ty;

  assign adx = (x1 > x2) ? x1 - x2 : x2 - x1;
  assign ady = (y1 > y2) ? y1 - y2 : y2 - y1;
  assign setup_x_major = adx > ady;

  always_comb begin
    if (setup_x_major) begin
      setup_span = adx;
      if (x1 <= x2) begin
        setup_lo = x1; setup_a = y1; setup_b = y2;
      end else begin
        setup_lo = x2; setup_a = y2; setup_b = y1;
      end
    end else begin
      setup_span = ady;
      if (y1 <= y2) begin
        setup_lo = y1; setup_a = x1; setup_b = x2;
      end else begin
        setup_lo = y2; setup_a = x2; setup_b = x1;
      end
    end
  end

  assign setup_d = $signed({1'b0, setup_b}) - $signed({1'b0, setup_a});
  assign err_sum = err + {{(EW-CW-2){d2[CW+1]}}, d2};
  assign two_n_s = $signed({{(EW-CW-1){1'b0}}, two_n});

  assign step_tx = x_major ? major : minor;
  assign step_ty = x_major ? minor : major;

  assign status.slot_free = !out_valid || out_ready;
  assign status.last_step = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= start_x;
      y1 <= start_y;
      x2 <= end_x;
      y2 <= end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x_major <= setup_x_major;
      major   <= setup_lo;
      minor   <= setup_a;
      cnt     <= setup_span;
      two_n   <= {setup_span, 1'b0};
      d2      <= {setup_d, 1'b0};
      err     <= $signed({{(EW-CW){1'b0}}, setup_span});
    end else if (cmd.step) begin
      major <= major + CW'(1);
      cnt   <= cnt - CW'(1);
      if (err_sum >= two_n_s) begin
        err   <= err_sum - two_n_s;
        minor <= minor + CW'(1);
      end else if (err_sum < 0) begin
        err   <= err_sum + two_n_s;
        minor <= minor - CW'(1);
      end else begin
        err   <= err_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tile_x <= step_tx;
      tile_y <= step_ty;
      in_map <= ({1'b0, step_tx} < map_width) && ({1'b0, step_ty} < map_height);
      last   <= status.last_step;
    end
  end

`ifndef SYNTHESIS
  a_step_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> out_valid)
    else $error("output slot empty after a step");

  a_err_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && two_n != '0) |-> (err >= 0 && err < two_n_s))
    else $error("error term outside its range");

  a_major_advances: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && cnt != '0) |=> (major == $past(major) + CW'(1)))
    else $error("major coordinate did not advance");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.last_step) |=> !cmd.step)
    else $error("step after the last tile");
`endif

endmodule

[hw/rtl/segment_tile_rasterizer.sv]
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: start_x, start_y, end_x, end_y
// m_axis    out  m_tvalid/m_tready  m_tdata: tile_x, tile_y; m_tuser: in_map; m_tlast
// apb       in   psel/penable       map_width at 0x0, map_height at 0x4
//
// A segment is handled in steps: accept, setup, then one tile per cycle while
// m_tready does not stall, for span + 1 tiles; span is the larger of |dx| and
// |dy|, at most 63. The tile stepper feeds a single output register.
// Reset is synchronous; it clears the controller and the output valid and sets both map registers to 64.
// A stalled m_tready holds the stepper; the next segment is taken once the last
// tile sits in the output register.
module segment_tile_rasterizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [23:0]                          s_tdata,  // start_x, start_y, end_x, end_y
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [15:0]                          m_tdata,  // tile_x, tile_y, 4 zero bits
  output logic                                 m_tuser,  // in_map
  output logic                                 m_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [segrast_pkg::ADDR_W-1:0]       paddr,
  input  logic [segrast_pkg::DATA_W-1:0]       pwdata,
  output logic [segrast_pkg::DATA_W-1:0]       prdata,
  output logic                                 pready
);

  localparam int CW = segrast_pkg::COORD_W;

  segrast_pkg::dp_cmd_t    cmd;
  segrast_pkg::dp_status_t status;

  logic [segrast_pkg::REG_W-1:0] map_width;
  logic [segrast_pkg::REG_W-1:0] map_height;
  logic [CW-1:0] tile_x, tile_y;

  segrast_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .map_width  (map_width),
    .map_height (map_height)
  );

  segrast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  segrast_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .start_x    (s_tdata[5:0]),
    .start_y    (s_tdata[11:6]),
    .end_x      (s_tdata[17:12]),
    .end_y      (s_tdata[23:18]),
    .map_width  (map_width),
    .map_height (map_height),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .in_map     (m_tuser),
    .last       (m_tlast)
  );

  assign m_tdata = {4'b0000, tile_y, tile_x};

endmodule

[tb/tb_segment_tile_rasterizer.sv]
module tb_segment_tile_rasterizer;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int GRID = 64;

  typedef struct packed {
    logic [segrast_pkg::COORD_W-1:0] ey;
    logic [segrast_pkg::COORD_W-1:0] ex;
    logic [segrast_pkg::COORD_W-1:0] sy;
    logic [segrast_pkg::COORD_W-1:0] sx;
  } segment_t;

  typedef struct packed {
    logic [segrast_pkg::COORD_W-1:0] x;
    logic [segrast_pkg::COORD_W-1:0] y;
    logic                            in_map;
    logic                            is_last;
  } tile_t;

  class tile_tracker;
    tile_t       expected_tiles[$];
    int unsigned map_width  = 64;
    int unsigned map_height = 64;
    int unsigned fail_count = 0;

    function void note_segment(segment_t s);
      int unsigned adx, ady, lo, a, b, span, minor, tx, ty, wlim, hlim;
      bit          x_major;
      tile_t       t;
      adx = (s.sx > s.ex) ? s.sx - s.ex : s.ex - s.sx;
      ady = (s.sy > s.ey) ? s.sy - s.ey : s.ey - s.sy;
      x_major = adx > ady;
      wlim = (map_width < GRID) ? map_width : GRID;
      hlim = (map_height < GRID) ? map_height : GRID;
      if (x_major) begin
        span = adx;
        if (s.sx <= s.ex) begin
          lo = s.sx; a = s.sy; b = s.ey;
        end else begin
          lo = s.ex; a = s.ey; b = s.sy;
        end
      end else begin
        span = ady;
        if (s.sy <= s.ey) begin
          lo = s.sy; a = s.sx; b = s.ex;
        end else begin
          lo = s.ey; a = s.ex; b = s.sx;
        end
      end
      for (int unsigned k = 0; k <= span; k++) begin
        minor = (span > 0) ? (2 * (a * (span - k) + b * k) + span) / (2 * span) : a;
        tx = x_major ? lo + k : minor;
        ty = x_major ? minor : lo + k;
        t.x = tx[segrast_pkg::COORD_W-1:0];
        t.y = ty[segrast_pkg::COORD_W-1:0];
        t.in_map = (tx < wlim) && (ty < hlim);
        t.is_last = (k == span);
        expected_tiles = {expected_tiles, t};
      end
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void check_tile(tile_t act);
      tile_t exp_t;
      if (expected_tiles.size() == 0) begin
        $display("%0t unexpected tile expected none actual x=%0d y=%0d in_map=%0b last=%0b",
                 $time, act.x, act.y, act.in_map, act.is_last);
        fail_count++;
      end else begin
        exp_t = expected_tiles.pop_front();
        check_field("tile_x", exp_t.x, act.x);
        check_field("tile_y", exp_t.y, act.y);
        check_field("in_map", exp_t.in_map, act.in_map);
        check_field("last", exp_t.is_last, act.is_last);
      end
    endfunction

    function int unsigned pending();
      return expected_tiles.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;  // start_x, start_y, end_x, end_y
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;       // tile_x, tile_y, 4 zero bits
  logic              m_tuser;       // in_map
  logic              m_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [segrast_pkg::ADDR_W-1:0] paddr = '0;
  logic [segrast_pkg::DATA_W-1:0] pwdata = '0;
  logic [segrast_pkg::DATA_W-1:0] prdata;
  logic              pready;

  tile_tracker tiles = new();
  int unsigned cycle_count = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_phase = '0;
  bit          sender_gaps = 1'b1;
  int unsigned burst_left = 0;

  segment_tile_rasterizer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tiles.note_segment(segment_t'(s_tdata));
    if (!rst && m_tvalid && m_tready)
      tiles.check_tile('{x: m_tdata[5:0], y: m_tdata[11:6], in_map: m_tuser, is_last: m_tlast});
  end

  task automatic send_segment(segment_t s);
    s_tdata <= s;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (sender_gaps) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic apb_write(logic idx, logic [segrast_pkg::REG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= segrast_pkg::DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == segrast_pkg::REG_MAP_WIDTH) tiles.map_width = value;
    else tiles.map_height = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apb_check(logic idx, logic [segrast_pkg::REG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== segrast_pkg::DATA_W'(value)) begin
      $display("%0t mismatch register %0d expected %0d actual %0d", $time, idx, value, prdata);
      tiles.fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (tiles.pending() != 0) @(negedge clk);
  endtask

  function automatic int clamp(int v);
    return (v < 0) ? 0 : (v > GRID - 1) ? GRID - 1 : v;
  endfunction

  function automatic segment_t mk_segment(int sx, int sy, int ex, int ey);
    segment_t s;
    s.sx = segrast_pkg::COORD_W'(clamp(sx));
    s.sy = segrast_pkg::COORD_W'(clamp(sy));
    s.ex = segrast_pkg::COORD_W'(clamp(ex));
    s.ey = segrast_pkg::COORD_W'(clamp(ey));
    return s;
  endfunction

  function automatic segment_t random_segment();
    int sx, sy, d;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    d = $urandom_range(1, 63);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return segment_t'(24'($urandom_range(0, 24'hFFFFFF)));
      4, 5, 6:
        return mk_segment(sx, sy, sx + $urandom_range(0, 10) - 5, sy + $urandom_range(0, 10) - 5);
      7: return $urandom_range(0, 1) ? mk_segment(sx, sy, $urandom_range(0, 63), sy)
                                     : mk_segment(sx, sy, sx, $urandom_range(0, 63));
      8: return mk_segment(sx, sy, $urandom_range(0, 1) ? sx + d : sx - d,
                           $urandom_range(0, 1) ? sy + d : sy - d);
      default: return mk_segment(sx, sy, sx, sy);
    endcase
  endfunction

  segment_t    directed[$];
  int          phase_w[7] = '{0, 64, 127, 1, 63, 65, 17};
  int          phase_h[7] = '{64, 0, 127, 1, 63, 33, 100};
  logic [segrast_pkg::REG_W-1:0] w_val, h_val;

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    directed = '{mk_segment(0, 0, 0, 0), mk_segment(63, 63, 63, 63),
                 mk_segment(0, 5, 63, 5), mk_segment(63, 5, 0, 5),
                 mk_segment(7, 0, 7, 63), mk_segment(7, 63, 7, 0),
                 mk_segment(0, 0, 63, 63), mk_segment(63, 63, 0, 0),
                 mk_segment(63, 0, 0, 63), mk_segment(0, 63, 63, 0),
                 mk_segment(0, 0, 2, 1), mk_segment(0, 1, 2, 0),
                 mk_segment(0, 0, 4, 1), mk_segment(1, 0, 0, 2),
                 mk_segment(0, 0, 63, 62), mk_segment(62, 0, 63, 63),
                 mk_segment(63, 0, 0, 1), mk_segment(10, 20, 11, 20),
                 mk_segment(42, 21, 21, 42), mk_segment(0, 63, 1, 0)};
    foreach (directed[i]) send_segment(directed[i]);
    s_tvalid <= 1'b0;
    drain();
    apb_check(segrast_pkg::REG_MAP_WIDTH, segrast_pkg::MAP_WIDTH_RESET);
    apb_check(segrast_pkg::REG_MAP_HEIGHT, segrast_pkg::MAP_HEIGHT_RESET);
    for (int p = 0; p < 7; p++) begin
      w_val = (p == 6) ? segrast_pkg::REG_W'($urandom_range(0, 127))
                       : segrast_pkg::REG_W'(phase_w[p]);
      h_val = (p == 6) ? segrast_pkg::REG_W'($urandom_range(0, 127))
                       : segrast_pkg::REG_W'(phase_h[p]);
      apb_write(segrast_pkg::REG_MAP_WIDTH, w_val);
      apb_write(segrast_pkg::REG_MAP_HEIGHT, h_val);
      apb_check(segrast_pkg::REG_MAP_WIDTH, w_val);
      apb_check(segrast_pkg::REG_MAP_HEIGHT, h_val);
      sender_gaps = (p % 3 != 0);
      ready_pattern = (p % 3 == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0101);
      repeat (40) send_segment(random_segment());
      s_tvalid <= 1'b0;
      drain();
    end
    repeat (12) @(posedge clk);
    if (tiles.fail_count == 0 && tiles.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/segrast_pkg.sv
hw/rtl/segrast_cfg.sv
hw/rtl/segrast_ctrl.sv
hw/rtl/segrast_datapath.sv
hw/rtl/segment_tile_rasterizer.sv
tb/tb_segment_tile_rasterizer.sv
